[sv/dll_pkg.sv]
// Shared types and constants for the doubly linked list manager.
// Used by dll_exec and doubly_linked_list_manager; depends on nothing.
package dll_pkg;

    // pool size and derived widths
    localparam int NODES  = 64;
    localparam int IDX_W  = $clog2(NODES);
    localparam int LINK_W = $clog2(NODES + 1);

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [IDX_W-1:0]  t_idx;

    // link value that points nowhere
    localparam t_link NIL = LINK_W'(NODES);

    // operation codes
    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_POP_TAIL = 2'd2,
        KIND_POP_HEAD = 2'd3
    } t_kind;

    // input transaction
    typedef struct packed {
        t_kind kind;
        t_idx  node_index;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic  ok;
        t_idx  popped_node;
        t_link count;
    } t_out_item;

    // list ends and occupancy
    typedef struct packed {
        t_link head;
        t_link tail;
        t_link count;
    } t_state;

    // state update and link writes produced by one operation;
    // the prev memory has a second port that only writes null
    typedef struct packed {
        t_state state;
        logic   prev_we;
        t_idx   prev_waddr;
        t_link  prev_wdata;
        logic   prev_clr_we;
        t_idx   prev_clr_addr;
        logic   next_we;
        t_idx   next_waddr;
        t_link  next_wdata;
    } t_upd;

endpackage

[sv/dll_exec.sv]
// Operation logic for the doubly linked list manager.
// Depends on dll_pkg; purely combinational, link reads come in registered.
module dll_exec (
    input  dll_pkg::t_in_item  i_op,
    input  dll_pkg::t_state    i_state,
    input  dll_pkg::t_link     i_prev_rd,
    input  dll_pkg::t_link     i_next_rd,
    output dll_pkg::t_out_item o_res,
    output dll_pkg::t_upd      o_upd
);

    // Every link is stored as written. For a remove the reads are the links
    // of the given node; for a pop tail the prev read is the link of the
    // tail, for a pop head the next read is the link of the head.
    always_comb begin
        dll_pkg::t_link n_l;
        dll_pkg::t_link cnt_inc;
        dll_pkg::t_link cnt_dec;
        dll_pkg::t_link taken;
        logic           n_valid;
        logic           ends_null;
        logic           empty;
        logic           ok;

        n_l       = dll_pkg::LINK_W'(i_op.node_index);
        n_valid   = n_l < dll_pkg::NIL;
        ends_null = !(i_state.head < dll_pkg::NIL) || !(i_state.tail < dll_pkg::NIL);
        empty     = (i_state.count == '0) || ends_null;

        // saturating count steps
        cnt_inc = (i_state.count < dll_pkg::NIL) ?
                  i_state.count + dll_pkg::LINK_W'(1) : i_state.count;
        cnt_dec = (i_state.count != '0) ?
                  i_state.count - dll_pkg::LINK_W'(1) : i_state.count;

        ok                  = 1'b0;
        taken               = '0;
        o_upd.state         = i_state;
        o_upd.prev_we       = 1'b0;
        o_upd.prev_waddr    = n_l[dll_pkg::IDX_W-1:0];
        o_upd.prev_wdata    = dll_pkg::NIL;
        o_upd.prev_clr_we   = 1'b0;
        o_upd.prev_clr_addr = n_l[dll_pkg::IDX_W-1:0];
        o_upd.next_we       = 1'b0;
        o_upd.next_waddr    = n_l[dll_pkg::IDX_W-1:0];
        o_upd.next_wdata    = dll_pkg::NIL;

        case (i_op.kind)
            dll_pkg::KIND_INSERT: begin
                if (n_valid) begin
                    ok            = 1'b1;
                    o_upd.prev_we = 1'b1;
                    o_upd.next_we = 1'b1;
                    if (ends_null) begin
                        // only node: both links null
                        o_upd.state.head = n_l;
                        o_upd.state.tail = n_l;
                    end else begin
                        // new node's prev goes null, old head points back to it;
                        // when the node is the head already the back link wins
                        o_upd.prev_clr_we = (n_l != i_state.head);
                        o_upd.prev_waddr  = i_state.head[dll_pkg::IDX_W-1:0];
                        o_upd.prev_wdata  = n_l;
                        o_upd.next_wdata  = i_state.head;
                        o_upd.state.head  = n_l;
                    end
                    o_upd.state.count = cnt_inc;
                end
            end
            dll_pkg::KIND_REMOVE: begin
                if (n_valid && !empty) begin
                    ok = 1'b1;
                    // splice the neighbors together
                    if (i_prev_rd < dll_pkg::NIL) begin
                        o_upd.next_we    = 1'b1;
                        o_upd.next_waddr = i_prev_rd[dll_pkg::IDX_W-1:0];
                        o_upd.next_wdata = i_next_rd;
                    end
                    if (i_next_rd < dll_pkg::NIL) begin
                        o_upd.prev_we    = 1'b1;
                        o_upd.prev_waddr = i_next_rd[dll_pkg::IDX_W-1:0];
                        o_upd.prev_wdata = i_prev_rd;
                    end
                    if (!(i_prev_rd < dll_pkg::NIL) && !(i_next_rd < dll_pkg::NIL)) begin
                        o_upd.state.head = dll_pkg::NIL;
                        o_upd.state.tail = dll_pkg::NIL;
                    end else if (!(i_next_rd < dll_pkg::NIL)) begin
                        o_upd.state.tail = i_prev_rd;
                    end else if (!(i_prev_rd < dll_pkg::NIL)) begin
                        o_upd.state.head = i_next_rd;
                    end
                    o_upd.state.count = cnt_dec;
                end
            end
            dll_pkg::KIND_POP_TAIL: begin
                if (!empty) begin
                    ok    = 1'b1;
                    taken = i_state.tail;
                    if (i_prev_rd < dll_pkg::NIL) begin
                        // new tail points nowhere forward
                        o_upd.state.tail = i_prev_rd;
                        o_upd.next_we    = 1'b1;
                        o_upd.next_waddr = i_prev_rd[dll_pkg::IDX_W-1:0];
                    end else begin
                        o_upd.state.head = dll_pkg::NIL;
                        o_upd.state.tail = dll_pkg::NIL;
                    end
                    o_upd.state.count = cnt_dec;
                end
            end
            dll_pkg::KIND_POP_HEAD: begin
                if (!empty) begin
                    ok    = 1'b1;
                    taken = i_state.head;
                    if (i_next_rd < dll_pkg::NIL) begin
                        // new head points nowhere back
                        o_upd.state.head = i_next_rd;
                        o_upd.prev_we    = 1'b1;
                        o_upd.prev_waddr = i_next_rd[dll_pkg::IDX_W-1:0];
                    end else begin
                        o_upd.state.head = dll_pkg::NIL;
                        o_upd.state.tail = dll_pkg::NIL;
                    end
                    o_upd.state.count = cnt_dec;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        o_res.ok          = ok;
        o_res.popped_node = taken[dll_pkg::IDX_W-1:0];
        o_res.count       = o_upd.state.count;
    end

endmodule

[sv/doubly_linked_list_manager.sv]
// Doubly linked list manager over a fixed pool of node handles.
// Depends on dll_pkg and dll_exec; holds the link memories and pipeline.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one operation
//   per transaction: insert at head, remove a given node, pop tail or pop
//   head. Output channel (o_out_valid / i_out_stall / o_out) returns one
//   result per operation, in order: ok flag, popped handle, new count.
//   The operation and its result are each registered. Throughput: one
//   operation per cycle unless stalled; each operation reads one entry of
//   each link memory (previous and next) at the edge it is taken and, when
//   it executes, writes at most one next entry and at most two previous
//   entries (an insert clears the new head and relinks the old one).
//   Reset: head and tail go null, the count goes to zero and both stages
//   empty; link memories are not cleared, and the user must see that no
//   entry is read before it has been written; the block does not enforce it.
//   Stall: while a result waits under i_out_stall, the operation behind it
//   holds in the input register and o_in_stall rises; one transaction is
//   still taken into an empty input register.
module doubly_linked_list_manager (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dll_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dll_pkg::t_out_item o_out
);

    logic               r_op_valid;
    dll_pkg::t_in_item  r_op;
    logic               r_res_valid;
    dll_pkg::t_out_item r_res;
    dll_pkg::t_state    r_state;
    dll_pkg::t_state    n_state;
    dll_pkg::t_link     r_prev_rd;
    dll_pkg::t_link     r_next_rd;
    dll_pkg::t_link     r_prev_mem [dll_pkg::NODES];
    dll_pkg::t_link     r_next_mem [dll_pkg::NODES];

    dll_pkg::t_out_item exec_res;
    dll_pkg::t_upd      exec_upd;
    dll_pkg::t_idx      prev_raddr;
    dll_pkg::t_idx      next_raddr;
    logic               advance;
    logic               exec;
    logic               in_acc;

    // handshake
    assign advance     = !r_res_valid || !i_out_stall;
    assign exec        = r_op_valid && advance;
    assign o_in_stall  = r_op_valid && !advance;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_res_valid;
    assign o_out       = r_res;

    // operation logic
    dll_exec u_exec (
        .i_op      (r_op),
        .i_state   (r_state),
        .i_prev_rd (r_prev_rd),
        .i_next_rd (r_next_rd),
        .o_res     (exec_res),
        .o_upd     (exec_upd)
    );

    // list ends as they stand after this edge
    assign n_state = exec ? exec_upd.state : r_state;

    // read addresses for the incoming operation
    always_comb begin
        if (i_in.kind == dll_pkg::KIND_REMOVE) begin
            prev_raddr = dll_pkg::IDX_W'(i_in.node_index);
            next_raddr = dll_pkg::IDX_W'(i_in.node_index);
        end else begin
            prev_raddr = n_state.tail[dll_pkg::IDX_W-1:0];
            next_raddr = n_state.head[dll_pkg::IDX_W-1:0];
        end
    end

    // link memories, read data forwarded from a write at the same edge;
    // the two prev ports never address the same entry
    always_ff @(posedge i_clk) begin
        if (exec && exec_upd.prev_clr_we) begin
            r_prev_mem[exec_upd.prev_clr_addr] <= dll_pkg::NIL;
        end
        if (exec && exec_upd.prev_we) begin
            r_prev_mem[exec_upd.prev_waddr] <= exec_upd.prev_wdata;
        end
        if (exec && exec_upd.next_we) begin
            r_next_mem[exec_upd.next_waddr] <= exec_upd.next_wdata;
        end
        if (in_acc) begin
            if (exec && exec_upd.prev_we && exec_upd.prev_waddr == prev_raddr) begin
                r_prev_rd <= exec_upd.prev_wdata;
            end else if (exec && exec_upd.prev_clr_we
                         && exec_upd.prev_clr_addr == prev_raddr) begin
                r_prev_rd <= dll_pkg::NIL;
            end else begin
                r_prev_rd <= r_prev_mem[prev_raddr];
            end
            if (exec && exec_upd.next_we && exec_upd.next_waddr == next_raddr) begin
                r_next_rd <= exec_upd.next_wdata;
            end else begin
                r_next_rd <= r_next_mem[next_raddr];
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= i_in;
        end
        if (exec) begin
            r_res <= exec_res;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_valid    <= 1'b0;
            r_res_valid   <= 1'b0;
            r_state.head  <= dll_pkg::NIL;
            r_state.tail  <= dll_pkg::NIL;
            r_state.count <= '0;
        end else begin
            if (!r_op_valid || advance) begin
                r_op_valid <= in_acc;
            end
            if (advance) begin
                r_res_valid <= r_op_valid;
            end
            r_state <= n_state;
        end
    end

    // head and tail go null together
    a_ends_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.head == dll_pkg::NIL) == (r_state.tail == dll_pkg::NIL))
        else $error("head and tail disagree on null");

    // a taken transaction lands in the input register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_op_valid)
        else $error("accepted operation lost");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_state.count == $past(r_state.count)
                  || r_state.count == $past(r_state.count) + dll_pkg::LINK_W'(1)
                  || r_state.count == $past(r_state.count) - dll_pkg::LINK_W'(1)))
        else $error("count jumped");

endmodule

[sim/tb_doubly_linked_list_manager.sv]
// Self-checking testbench for doubly_linked_list_manager: a directed set of list
// operations, then random insert/remove/pop traffic, checked against a local deque predictor.
// Depends on dll_pkg and the doubly_linked_list_manager RTL.
`timescale 1ns / 1ps

module tb_doubly_linked_list_manager;

    localparam int RANDOM_OPS  = 1500;
    localparam int DRAIN_WAIT  = 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    dll_pkg::t_in_item  in_item = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    dll_pkg::t_out_item out_item;

    doubly_linked_list_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    // clock and a single reset pulse
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Deque predictor: own copy of the links, ends and count
    // ------------------------------------------------------------------
    dll_pkg::t_link nd_prev [dll_pkg::NODES];
    dll_pkg::t_link nd_next [dll_pkg::NODES];
    dll_pkg::t_link list_head;
    dll_pkg::t_link list_tail;
    dll_pkg::t_link list_count;

    function automatic bit is_node(input dll_pkg::t_link h);
        return h < dll_pkg::NODES;
    endfunction

    task automatic list_clear();
        for (int i = 0; i < dll_pkg::NODES; i++) begin
            nd_prev[i] = '0;
            nd_next[i] = '0;
        end
        list_head  = dll_pkg::NIL;
        list_tail  = dll_pkg::NIL;
        list_count = '0;
    endtask

    // applies one operation to the predicted list and returns the result
    function automatic dll_pkg::t_out_item list_apply(input dll_pkg::t_in_item op);
        dll_pkg::t_out_item res;
        dll_pkg::t_link     n;
        dll_pkg::t_link     p;
        dll_pkg::t_link     q;
        dll_pkg::t_link     taken;
        bit                 empty;
        res   = '0;
        n     = dll_pkg::t_link'(op.node_index);
        taken = '0;
        empty = (list_count == 0) || !is_node(list_head) || !is_node(list_tail);
        case (op.kind)
            dll_pkg::KIND_INSERT: begin
                // either end null: node becomes the only one
                if (!is_node(list_head) || !is_node(list_tail)) begin
                    nd_prev[n] = dll_pkg::NIL;
                    nd_next[n] = dll_pkg::NIL;
                    list_head  = n;
                    list_tail  = n;
                end else begin
                    nd_prev[n]         = dll_pkg::NIL;
                    nd_prev[list_head] = n;
                    nd_next[n]         = list_head;
                    list_head          = n;
                end
                if (list_count < dll_pkg::NODES) list_count++;
                res.ok = 1'b1;
            end
            dll_pkg::KIND_REMOVE: begin
                if (!empty) begin
                    p = nd_prev[n];
                    q = nd_next[n];
                    if (is_node(p)) nd_next[p] = q;
                    if (is_node(q)) nd_prev[q] = p;
                    if (!is_node(p) && !is_node(q)) begin
                        list_head = dll_pkg::NIL;
                        list_tail = dll_pkg::NIL;
                    end else if (!is_node(q)) begin
                        list_tail = p;
                    end else if (!is_node(p)) begin
                        list_head = q;
                    end
                    if (list_count > 0) list_count--;
                    res.ok = 1'b1;
                end
            end
            dll_pkg::KIND_POP_TAIL: begin
                if (!empty) begin
                    taken     = list_tail;
                    list_tail = nd_prev[taken];
                    // new tail must not point past itself
                    if (is_node(list_tail)) begin
                        nd_next[list_tail] = dll_pkg::NIL;
                    end else begin
                        list_tail = dll_pkg::NIL;
                        list_head = dll_pkg::NIL;
                    end
                    if (list_count > 0) list_count--;
                    res.ok = 1'b1;
                end
            end
            default: begin
                if (!empty) begin
                    taken     = list_head;
                    list_head = nd_next[taken];
                    if (is_node(list_head)) begin
                        nd_prev[list_head] = dll_pkg::NIL;
                    end else begin
                        list_head = dll_pkg::NIL;
                        list_tail = dll_pkg::NIL;
                    end
                    if (list_count > 0) list_count--;
                    res.ok = 1'b1;
                end
            end
        endcase
        res.popped_node = res.ok ? taken[dll_pkg::IDX_W-1:0] : '0;
        res.count       = list_count;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    dll_pkg::t_in_item  pending_ops [$];
    dll_pkg::t_out_item expected_results [$];

    int        gen_list [$];     // what the list should hold if traffic is well formed
    bit [63:0] gen_member;
    bit [63:0] ever_inserted;

    task automatic queue_op(input dll_pkg::t_kind k, input int idx);
        dll_pkg::t_in_item op;
        op.kind       = k;
        op.node_index = idx[5:0];
        if (k == dll_pkg::KIND_INSERT) ever_inserted[idx] = 1'b1;
        pending_ops.push_back(op);
    endtask

    // any node whose links have been written at least once
    function automatic int pick_written_node();
        int j;
        do j = $urandom_range(0, dll_pkg::NODES - 1); while (!ever_inserted[j]);
        return j;
    endfunction

    task automatic gen_remove_at(input int pos);
        queue_op(dll_pkg::KIND_REMOVE, gen_list[pos]);
        gen_member[gen_list[pos]] = 1'b0;
        gen_list.delete(pos);
    endtask

    task automatic build_directed();
        // operations on an empty list are refused
        queue_op(dll_pkg::KIND_POP_HEAD, 0);
        queue_op(dll_pkg::KIND_POP_TAIL, 63);
        queue_op(dll_pkg::KIND_REMOVE, 63);
        // single node leaving through either end
        queue_op(dll_pkg::KIND_INSERT, 0);
        queue_op(dll_pkg::KIND_POP_TAIL, 0);
        queue_op(dll_pkg::KIND_INSERT, 63);
        queue_op(dll_pkg::KIND_POP_HEAD, 0);
        // removal from middle, head, tail, then the last node
        queue_op(dll_pkg::KIND_INSERT, 0);
        queue_op(dll_pkg::KIND_INSERT, 63);
        queue_op(dll_pkg::KIND_INSERT, 21);
        queue_op(dll_pkg::KIND_INSERT, 42);
        queue_op(dll_pkg::KIND_REMOVE, 63);
        queue_op(dll_pkg::KIND_REMOVE, 42);
        queue_op(dll_pkg::KIND_REMOVE, 0);
        queue_op(dll_pkg::KIND_REMOVE, 21);
        // pops that need the outward link of the new end cleared
        queue_op(dll_pkg::KIND_INSERT, 5);
        queue_op(dll_pkg::KIND_INSERT, 6);
        queue_op(dll_pkg::KIND_INSERT, 7);
        queue_op(dll_pkg::KIND_POP_TAIL, 42);
        queue_op(dll_pkg::KIND_POP_HEAD, 21);
        queue_op(dll_pkg::KIND_POP_HEAD, 63);
        // same node inserted twice, then popped out and removed
        queue_op(dll_pkg::KIND_INSERT, 9);
        queue_op(dll_pkg::KIND_INSERT, 9);
        queue_op(dll_pkg::KIND_POP_HEAD, 0);
        queue_op(dll_pkg::KIND_POP_HEAD, 0);
        queue_op(dll_pkg::KIND_REMOVE, 9);
    endtask

    task automatic build_random();
        bit fill_mode;
        int mode_left;
        int roll;
        int ins_pct;
        int j;
        int pos;
        fill_mode = 1'b1;
        mode_left = $urandom_range(60, 200);
        gen_list.delete();
        gen_member = '0;
        for (int i = 0; i < RANDOM_OPS; i++) begin
            // alternate between growing and shrinking the list
            mode_left--;
            if (mode_left <= 0) begin
                fill_mode = !fill_mode;
                mode_left = $urandom_range(60, 200);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                // malformed traffic: duplicate insert, or removal of any node ever inserted
                if (gen_list.size() > 0 && $urandom_range(0, 1)) begin
                    queue_op(dll_pkg::KIND_INSERT,
                             gen_list[$urandom_range(0, gen_list.size() - 1)]);
                end else begin
                    j = pick_written_node();
                    queue_op(dll_pkg::KIND_REMOVE, j);
                    if (gen_member[j]) begin
                        foreach (gen_list[k]) if (gen_list[k] == j) pos = k;
                        gen_member[j] = 1'b0;
                        gen_list.delete(pos);
                    end
                end
            end else begin
                ins_pct = fill_mode ? 70 : 30;
                roll    = $urandom_range(0, 99);
                if (roll < ins_pct) begin
                    // fresh node if one is free; a full pool forces a duplicate
                    if (gen_list.size() < dll_pkg::NODES) begin
                        do j = $urandom_range(0, dll_pkg::NODES - 1); while (gen_member[j]);
                        gen_member[j] = 1'b1;
                        gen_list.push_front(j);
                    end else begin
                        j = $urandom_range(0, dll_pkg::NODES - 1);
                    end
                    queue_op(dll_pkg::KIND_INSERT, j);
                end else if (roll < ins_pct + (100 - ins_pct) / 3) begin
                    if (gen_list.size() > 0)
                        gen_remove_at($urandom_range(0, gen_list.size() - 1));
                    else
                        queue_op(dll_pkg::KIND_REMOVE, pick_written_node());
                end else if ($urandom_range(0, 1)) begin
                    queue_op(dll_pkg::KIND_POP_TAIL, $urandom_range(0, dll_pkg::NODES - 1));
                    if (gen_list.size() > 0) gen_member[gen_list.pop_back()] = 1'b0;
                end else begin
                    queue_op(dll_pkg::KIND_POP_HEAD, $urandom_range(0, dll_pkg::NODES - 1));
                    if (gen_list.size() > 0) gen_member[gen_list.pop_front()] = 1'b0;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Traffic shaping: four idling phases with quiet stretches
    // ------------------------------------------------------------------
    int n_total;
    int n_accepted;
    int quiet_left = 0;

    function automatic int idle_phase();
        return (n_total == 0) ? 0 : (n_accepted * 4) / n_total;
    endfunction

    function automatic bit sender_gap();
        int pct;
        case (idle_phase())
            1:       pct = 62;
            3:       pct = 7;
            default: pct = 0;
        endcase
        return quiet_left == 0 && $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit receiver_hold();
        int pct;
        case (idle_phase())
            2:       pct = 62;
            3:       pct = 7;
            default: pct = 0;
        endcase
        return quiet_left == 0 && $urandom_range(0, 99) < pct;
    endfunction

    // ------------------------------------------------------------------
    // Error reporting and run statistics
    // ------------------------------------------------------------------
    int n_errors;
    int n_results;
    int n_insert_ok;
    int n_remove_ok;
    int n_pop_ok;
    int n_refused;
    int peak_count;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued operations, holds them while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        dll_pkg::t_out_item want;
        bit                 taken;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && !in_stall;
            if (taken) begin
                want = list_apply(in_item);
                expected_results.push_back(want);
                n_accepted++;
                if (!want.ok)                                   n_refused++;
                else if (in_item.kind == dll_pkg::KIND_INSERT)  n_insert_ok++;
                else if (in_item.kind == dll_pkg::KIND_REMOVE)  n_remove_ok++;
                else                                            n_pop_ok++;
                if (want.count > peak_count) peak_count = want.count;
            end
            if (in_valid && !taken) begin
                // stalled transaction stays on the bus unchanged
            end else if (pending_ops.size() > 0 && !sender_gap()) begin
                in_item  <= pending_ops.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        dll_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("unexpected result ok=%0b node=%0d count=%0d",
                                         out_item.ok, out_item.popped_node, out_item.count));
                end else begin
                    want = expected_results.pop_front();
                    n_results++;
                    if (out_item.ok !== want.ok)
                        flag_error($sformatf("result %0d: ok %0b, expected %0b",
                                             n_results, out_item.ok, want.ok));
                    if (out_item.popped_node !== want.popped_node)
                        flag_error($sformatf("result %0d: popped node %0d, expected %0d",
                                             n_results, out_item.popped_node,
                                             want.popped_node));
                    if (out_item.count !== want.count)
                        flag_error($sformatf("result %0d: count %0d, expected %0d",
                                             n_results, out_item.count, want.count));
                end
            end
            out_stall <= receiver_hold();
            // occasional stretch with no idling on either side
            if (quiet_left > 0)
                quiet_left <= quiet_left - 1;
            else if ($urandom_range(0, 99) == 0)
                quiet_left <= $urandom_range(16, 64);
        end
    end

    // ------------------------------------------------------------------
    // Sequencing and end of run
    // ------------------------------------------------------------------
    initial begin
        list_clear();
        ever_inserted = '0;
        build_directed();
        build_random();
        n_total = pending_ops.size();

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (pending_ops.size() > 0 || in_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d operations: %0d inserts, %0d removes, %0d pops succeeded, %0d refused",
                 n_accepted, n_insert_ok, n_remove_ok, n_pop_ok, n_refused);
        $display("Checked %0d results, peak list count %0d", n_results, peak_count);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Timeout: %0d results outstanding", expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
